### rtl/stta_pkg.sv
`default_nettype none
package stta_pkg;

    localparam int MaxResults = 32;

    // request kinds
    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_TICK   = 2'd3
    } req_kind_t;

    // report kinds
    localparam logic [2:0] EV_HIT     = 3'd0;
    localparam logic [2:0] EV_MISS    = 3'd1;
    localparam logic [2:0] EV_ADDED   = 3'd2;
    localparam logic [2:0] EV_REMOVED = 3'd3;
    localparam logic [2:0] EV_SOURCE  = 3'd4;
    localparam logic [2:0] EV_STATUS  = 3'd5;
    localparam logic [2:0] EV_FULL    = 3'd6;

    localparam logic [1:0] ST_RUNNING    = 2'd0;
    localparam logic [1:0] ST_TERMINATED = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_PR,
        S_FIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] svc_id;
        logic [15:0] inst_id;
        logic [31:0] net_address;
        logic [15:0] net_port;
        logic [1:0]  run_status;
        logic [7:0]  ver_major;
        logic        transport_kind;
        logic [2:0]  origin_kind;
        logic [1:0]  access_kind;
    } req_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [15:0] rep_service_id;
        logic [15:0] rep_instance_id;
        logic [31:0] rep_address;
        logic [15:0] rep_port;
        logic [1:0]  rep_status;
        logic [7:0]  rep_version;
        logic        rep_transport;
        logic [2:0]  rep_origin;
        logic [1:0]  rep_access;
        logic [7:0]  rep_time_left;
        logic        last_event;
    } rsp_t;

    // one stored table row
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] addr;
        logic [15:0] port;
        logic [15:0] attr;
        logic [7:0]  tl;
    } row_t;

    localparam int RowWidth = $bits(row_t);

    // output queue status toward the sequencer
    typedef struct packed {
        logic can_push;
        logic can_flush;
        logic hold_v;
    } oq_stat_t;

    function automatic rsp_t make_rsp(logic [2:0] kind, row_t r);
        rsp_t o;
        o.event_kind      = kind;
        o.rep_service_id  = r.key[31:16];
        o.rep_instance_id = r.key[15:0];
        o.rep_address     = r.addr;
        o.rep_port        = r.port;
        o.rep_status      = r.attr[1:0];
        o.rep_version     = r.attr[9:2];
        o.rep_transport   = r.attr[10];
        o.rep_origin      = r.attr[13:11];
        o.rep_access      = r.attr[15:14];
        o.rep_time_left   = r.tl;
        o.last_event      = 1'b0;
        return o;
    endfunction

endpackage
`default_nettype wire

### rtl/stta_ram.sv
`default_nettype none
module stta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### rtl/stta_outq.sv
`default_nettype none
module stta_outq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire stta_pkg::rsp_t    push_data,
    input  wire logic              flush,
    output stta_pkg::oq_stat_t     stat,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output stta_pkg::rsp_t         m_data
);

    logic           hold_v_reg, hold_v_next;
    stta_pkg::rsp_t hold_reg, hold_next;
    logic           out_v_reg, out_v_next;
    stta_pkg::rsp_t out_reg, out_next;
    logic           out_free;

    assign out_free       = !out_v_reg || m_ready;
    assign stat.can_push  = !hold_v_reg || out_free;
    assign stat.can_flush = !hold_v_reg || out_free;
    assign stat.hold_v    = hold_v_reg;
    assign m_valid        = out_v_reg;
    assign m_data         = out_reg;

    // newest word waits in hold until the next one or the end tells its last flag
    always_comb begin
        hold_v_next = hold_v_reg;
        hold_next   = hold_reg;
        out_v_next  = out_v_reg && !m_ready;
        out_next    = out_reg;
        if (push) begin
            if (hold_v_reg) begin
                out_next            = hold_reg;
                out_next.last_event = 1'b0;
                out_v_next          = 1'b1;
            end
            hold_next   = push_data;
            hold_v_next = 1'b1;
        end else if (flush && hold_v_reg) begin
            out_next            = hold_reg;
            out_next.last_event = 1'b1;
            out_v_next          = 1'b1;
            hold_v_next         = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            hold_v_reg <= hold_v_next;
            out_v_reg  <= out_v_next;
        end
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    ap_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> stat.can_push) else $error("push into full queue");
    ap_flush_room: assert property (@(posedge aclk) disable iff (!aresetn)
        flush |-> stat.can_flush) else $error("flush without room");
    ap_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("word dropped");

endmodule
`default_nettype wire

### rtl/service_table_with_ttl_aging_core.sv
`default_nettype none
// Service table with aging. Entries live in one RAM row per slot (key, address,
// port, attributes, time left); valid marks sit in flip-flops and clear at reset.
// Each request scans the slots one at a time, reading each slot and then
// processing it (S_RD, then S_PR), for add, remove, lookup and tick alike;
// any request may stretch further while the result side stalls, a tick most. One
// request is handled at a time; s_ready is high only between requests. Tick
// reports leave in slot order, and the final word of every request carries last_event.
module service_table_with_ttl_aging_core #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_we,
    input  wire logic [7:0]      cfg_wdata,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire stta_pkg::req_t  s_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output stta_pkg::rsp_t       m_data
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IW-1:0] LastIdx = IW'(TABLE_DEPTH - 1);
    localparam logic [5:0]    CapCnt  = 6'(stta_pkg::MaxResults);

    stta_pkg::state_t   state_reg, state_next;
    stta_pkg::req_t     req_reg, req_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic               found_reg, found_next;
    logic [IW-1:0]      found_idx_reg, found_idx_next;
    logic               free_reg, free_next;
    logic [IW-1:0]      free_idx_reg, free_idx_next;
    stta_pkg::row_t     cap_reg, cap_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [7:0]         ttl_reg;

    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    stta_pkg::row_t     ram_wdata, ram_rdata;
    logic               push, flush;
    stta_pkg::rsp_t     push_data;
    stta_pkg::oq_stat_t oq_stat;

    stta_pkg::row_t     req_row;
    logic [31:0]        req_key;
    logic               slot_hit;
    logic [1:0]         cur_st;
    logic [7:0]         cur_tl;
    logic               report;
    stta_pkg::row_t     aged_row;

    assign req_key = {req_reg.svc_id, req_reg.inst_id};

    // request fields as a row
    always_comb begin
        req_row.key  = req_key;
        req_row.addr = req_reg.net_address;
        req_row.port = req_reg.net_port;
        req_row.attr = {req_reg.access_kind, req_reg.origin_kind, req_reg.transport_kind,
                        req_reg.ver_major, req_reg.run_status};
        req_row.tl   = ttl_reg;
    end

    // aging of the slot just read
    always_comb begin
        slot_hit = valid_reg[idx_reg] && (ram_rdata.key == req_key);
        cur_st   = ram_rdata.attr[1:0];
        cur_tl   = ram_rdata.tl;
        if (cur_st == stta_pkg::ST_RUNNING && cur_tl != 8'd0) begin
            cur_tl = cur_tl - 8'd1;
        end
        report   = valid_reg[idx_reg] && cur_tl == 8'd0
                && cur_st != stta_pkg::ST_TERMINATED && cnt_reg < CapCnt;
        aged_row = ram_rdata;
        aged_row.tl = cur_tl;
        if (report) begin
            aged_row.attr[1:0] = stta_pkg::ST_TERMINATED;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stta_pkg::S_IDLE: if (s_valid) state_next = stta_pkg::S_RD;
            stta_pkg::S_RD:   state_next = stta_pkg::S_PR;
            stta_pkg::S_PR: begin
                if (!(req_reg.req_type == stta_pkg::REQ_TICK && report
                      && !oq_stat.can_push)) begin
                    if (idx_reg != LastIdx) begin
                        state_next = stta_pkg::S_RD;
                    end else if (req_reg.req_type == stta_pkg::REQ_TICK) begin
                        state_next = stta_pkg::S_DONE;
                    end else begin
                        state_next = stta_pkg::S_FIN;
                    end
                end
            end
            stta_pkg::S_FIN:  state_next = stta_pkg::S_DONE;
            stta_pkg::S_DONE: if (oq_stat.can_flush) state_next = stta_pkg::S_IDLE;
            default:          state_next = stta_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        req_next       = req_reg;
        idx_next       = idx_reg;
        valid_next     = valid_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        cap_next       = cap_reg;
        cnt_next       = cnt_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = aged_row;
        push           = 1'b0;
        push_data      = stta_pkg::make_rsp(stta_pkg::EV_STATUS, aged_row);
        flush          = 1'b0;
        s_ready        = 1'b0;
        unique case (state_reg)
            stta_pkg::S_IDLE: begin
                s_ready    = 1'b1;
                req_next   = s_data;
                idx_next   = '0;
                found_next = 1'b0;
                free_next  = 1'b0;
                cnt_next   = '0;
            end
            stta_pkg::S_RD: begin
            end
            stta_pkg::S_PR: begin
                if (req_reg.req_type == stta_pkg::REQ_TICK) begin
                    if (!(report && !oq_stat.can_push)) begin
                        ram_we = valid_reg[idx_reg];
                        push   = report;
                        if (report) cnt_next = cnt_reg + 6'd1;
                        idx_next = idx_reg + IW'(1);
                    end
                end else begin
                    if (slot_hit) begin
                        found_next     = 1'b1;
                        found_idx_next = idx_reg;
                        cap_next       = ram_rdata;
                    end
                    if (!valid_reg[idx_reg] && !free_reg) begin
                        free_next     = 1'b1;
                        free_idx_next = idx_reg;
                    end
                    idx_next = idx_reg + IW'(1);
                end
            end
            stta_pkg::S_FIN: begin
                ram_wdata = req_row;
                unique case (req_reg.req_type)
                    stta_pkg::REQ_ADD: begin
                        if (found_reg) begin
                            ram_we    = 1'b1;
                            ram_waddr = found_idx_reg;
                            if (cap_reg.addr != req_row.addr || cap_reg.port != req_row.port) begin
                                push      = 1'b1;
                                push_data = stta_pkg::make_rsp(stta_pkg::EV_SOURCE, req_row);
                            end else if (cap_reg.attr[1:0] != req_row.attr[1:0]) begin
                                push      = 1'b1;
                                push_data = stta_pkg::make_rsp(stta_pkg::EV_STATUS, req_row);
                            end
                        end else if (free_reg) begin
                            ram_we    = 1'b1;
                            ram_waddr = free_idx_reg;
                            valid_next[free_idx_reg] = 1'b1;
                            push      = 1'b1;
                            push_data = stta_pkg::make_rsp(stta_pkg::EV_ADDED, req_row);
                        end else begin
                            push      = 1'b1;
                            push_data = stta_pkg::make_rsp(stta_pkg::EV_FULL,
                                            '{key: req_row.key, addr: req_row.addr,
                                              port: req_row.port, attr: req_row.attr,
                                              tl: 8'd0});
                        end
                    end
                    stta_pkg::REQ_REMOVE: begin
                        if (found_reg) begin
                            valid_next[found_idx_reg] = 1'b0;
                            push      = 1'b1;
                            push_data = stta_pkg::make_rsp(stta_pkg::EV_REMOVED, cap_reg);
                        end
                    end
                    stta_pkg::REQ_LOOKUP: begin
                        push = 1'b1;
                        if (found_reg) begin
                            push_data = stta_pkg::make_rsp(stta_pkg::EV_HIT, cap_reg);
                        end else begin
                            push_data = stta_pkg::make_rsp(stta_pkg::EV_MISS,
                                            '{key: {16'd0, req_reg.inst_id},
                                              addr: 32'd0, port: 16'd0, attr: 16'd0,
                                              tl: 8'd0});
                        end
                    end
                    default: begin
                    end
                endcase
            end
            stta_pkg::S_DONE: begin
                flush = oq_stat.can_flush;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stta_pkg::S_IDLE;
            valid_reg <= '0;
            ttl_reg   <= 8'd10;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            if (cfg_we) ttl_reg <= cfg_wdata;
        end
        req_reg       <= req_next;
        idx_reg       <= idx_next;
        found_reg     <= found_next;
        found_idx_reg <= found_idx_next;
        free_reg      <= free_next;
        free_idx_reg  <= free_idx_next;
        cap_reg       <= cap_next;
    end

    stta_ram #(
        .WIDTH (stta_pkg::RowWidth),
        .DEPTH (TABLE_DEPTH),
        .AW    (IW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    stta_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .flush     (flush),
        .stat      (oq_stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    ap_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CapCnt) else $error("tick report count over cap");
    ap_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == stta_pkg::S_IDLE |-> !oq_stat.hold_v) else $error("held word at idle");
    ap_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == stta_pkg::S_RD) else $error("scan not started");
    ap_write_when: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> state_reg == stta_pkg::S_PR || state_reg == stta_pkg::S_FIN)
        else $error("stray table write");

endmodule
`default_nettype wire

### verif/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Depth = 32;
    localparam int CycleLimit = 2000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;
    logic s_valid = 1'b0;
    logic s_ready;
    stta_pkg::req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    stta_pkg::rsp_t m_data;

    service_table_with_ttl_aging_core #(.TABLE_DEPTH(Depth)) dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #2 aclk = ~aclk;

    // predictor state: shadow copy of the table
    logic [7:0]  ttl_now;
    logic        tv [Depth];
    logic [31:0] tkey [Depth];
    logic [31:0] taddr [Depth];
    logic [15:0] tport [Depth];
    logic [15:0] tattr [Depth];
    logic [7:0]  ttl [Depth];

    stta_pkg::req_t pending_words [$];
    stta_pkg::rsp_t expected_reports [$];
    int   mismatches = 0;
    int   cycles = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   send_hold = 1'b0;

    function automatic stta_pkg::rsp_t mk(logic [2:0] kind, logic [31:0] key,
                                          logic [31:0] a, logic [15:0] p,
                                          logic [15:0] at, logic [7:0] t);
        stta_pkg::rsp_t r;
        r.event_kind = kind;
        r.rep_service_id = key[31:16];
        r.rep_instance_id = key[15:0];
        r.rep_address = a;
        r.rep_port = p;
        r.rep_status = at[1:0];
        r.rep_version = at[9:2];
        r.rep_transport = at[10];
        r.rep_origin = at[13:11];
        r.rep_access = at[15:14];
        r.rep_time_left = t;
        r.last_event = 1'b0;
        return r;
    endfunction

    // work out the reports that one accepted word causes
    task automatic predict_table(input stta_pkg::req_t q);
        logic [31:0] key;
        logic [15:0] at;
        stta_pkg::rsp_t out [$];
        int s;
        int f;
        logic [2:0] kind;
        bit any;
        key = {q.svc_id, q.inst_id};
        at = {q.access_kind, q.origin_kind, q.transport_kind, q.ver_major, q.run_status};
        s = -1;
        f = -1;
        for (int i = 0; i < Depth; i++) begin
            if (tv[i] && tkey[i] == key && s < 0) s = i;
            if (!tv[i] && f < 0) f = i;
        end
        case (q.req_type)
            stta_pkg::REQ_ADD: begin
                if (s < 0) begin
                    if (f < 0) begin
                        out.push_back(mk(stta_pkg::EV_FULL, key, q.net_address, q.net_port,
                                         at, 8'd0));
                    end else begin
                        tv[f] = 1'b1; tkey[f] = key; taddr[f] = q.net_address;
                        tport[f] = q.net_port; tattr[f] = at; ttl[f] = ttl_now;
                        out.push_back(mk(stta_pkg::EV_ADDED, key, q.net_address, q.net_port,
                                         at, ttl_now));
                    end
                end else begin
                    any = 1'b1;
                    kind = stta_pkg::EV_SOURCE;
                    if (taddr[s] != q.net_address || tport[s] != q.net_port)
                        kind = stta_pkg::EV_SOURCE;
                    else if (tattr[s][1:0] != at[1:0]) kind = stta_pkg::EV_STATUS;
                    else any = 1'b0;
                    taddr[s] = q.net_address; tport[s] = q.net_port;
                    tattr[s] = at; ttl[s] = ttl_now;
                    if (any) out.push_back(mk(kind, key, q.net_address, q.net_port, at, ttl_now));
                end
            end
            stta_pkg::REQ_REMOVE: begin
                if (s >= 0) begin
                    tv[s] = 1'b0;
                    out.push_back(mk(stta_pkg::EV_REMOVED, key, taddr[s], tport[s], tattr[s],
                                     ttl[s]));
                end
            end
            stta_pkg::REQ_LOOKUP: begin
                if (s >= 0)
                    out.push_back(mk(stta_pkg::EV_HIT, key, taddr[s], tport[s], tattr[s],
                                     ttl[s]));
                else
                    out.push_back(mk(stta_pkg::EV_MISS, {16'd0, key[15:0]}, '0, '0, '0, '0));
            end
            default: begin
                for (int i = 0; i < Depth; i++) begin
                    if (tv[i]) begin
                        if (tattr[i][1:0] == stta_pkg::ST_RUNNING && ttl[i] > 0)
                            ttl[i] = ttl[i] - 8'd1;
                        if (ttl[i] == 0 && tattr[i][1:0] != stta_pkg::ST_TERMINATED
                            && out.size() < stta_pkg::MaxResults) begin
                            tattr[i][1:0] = stta_pkg::ST_TERMINATED;
                            out.push_back(mk(stta_pkg::EV_STATUS, tkey[i], taddr[i], tport[i],
                                             tattr[i], 8'd0));
                        end
                    end
                end
            end
        endcase
        if (out.size() > 0) out[out.size() - 1].last_event = 1'b1;
        foreach (out[k]) expected_reports.push_back(out[k]);
    endtask

    // driver: present words from the pending queue
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_table(s_data);
                void'(pending_words.pop_front());
            end
            if (s_valid && !s_ready) begin
                // hold
            end else if (!send_hold && pending_words.size() > 0
                         && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data <= pending_words[0];
            end else begin
                s_valid <= 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: compare each report word with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected report word %h", m_data);
            end else begin
                if (m_data !== expected_reports[0]) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("report mismatch: expected %h actual %h",
                                 expected_reports[0], m_data);
                end
                void'(expected_reports.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic stta_pkg::req_t rand_word(logic [1:0] kind, int keyspan);
        stta_pkg::req_t q;
        q.req_type = kind;
        q.svc_id = (keyspan == 0) ? 16'($urandom) : 16'($urandom_range(keyspan));
        q.inst_id = (keyspan == 0) ? 16'($urandom) : 16'($urandom_range(keyspan));
        q.net_address = ($urandom_range(3) == 0) ? 32'($urandom_range(1)) : $urandom;
        q.net_port = ($urandom_range(3) == 0) ? 16'd7 : 16'($urandom);
        q.run_status = 2'($urandom_range(3));
        q.ver_major = 8'($urandom);
        q.transport_kind = 1'($urandom);
        q.origin_kind = 3'($urandom);
        q.access_kind = 2'($urandom);
        return q;
    endfunction

    task automatic wait_drained();
        while (pending_words.size() > 0 || s_valid || expected_reports.size() > 0)
            @(posedge aclk);
        repeat (2 * Depth + 20) @(posedge aclk);
    endtask

    task automatic write_ttl(input logic [7:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        ttl_now = v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_random(input int n, input int keyspan);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 40) pending_words.push_back(rand_word(stta_pkg::REQ_ADD, keyspan));
            else if (r < 55) pending_words.push_back(rand_word(stta_pkg::REQ_REMOVE, keyspan));
            else if (r < 75) pending_words.push_back(rand_word(stta_pkg::REQ_LOOKUP, keyspan));
            else pending_words.push_back(rand_word(stta_pkg::REQ_TICK, keyspan));
        end
    endtask

    initial begin
        stta_pkg::req_t q;
        ttl_now = 8'd10;
        for (int i = 0; i < Depth; i++) begin
            tv[i] = 1'b0; tkey[i] = '0; taddr[i] = '0;
            tport[i] = '0; tattr[i] = '0; ttl[i] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, each request kind, overwrite cases
        q = '1; q.req_type = stta_pkg::REQ_ADD; q.run_status = stta_pkg::ST_RUNNING;
        pending_words.push_back(q);
        q.req_type = stta_pkg::REQ_LOOKUP; pending_words.push_back(q);
        q.req_type = stta_pkg::REQ_ADD; q.run_status = 2'd3; pending_words.push_back(q);
        q.net_port = 16'd0; pending_words.push_back(q);
        q.req_type = stta_pkg::REQ_ADD; pending_words.push_back(q);
        q.req_type = stta_pkg::REQ_REMOVE; pending_words.push_back(q);
        pending_words.push_back(q);
        q = '0; q.req_type = stta_pkg::REQ_LOOKUP; q.inst_id = 16'hffff;
        pending_words.push_back(q);
        q = '0; q.req_type = stta_pkg::REQ_ADD; pending_words.push_back(q);
        q.req_type = stta_pkg::REQ_TICK; pending_words.push_back(q);
        for (int i = 0; i < 12; i++) begin
            q = rand_word(stta_pkg::REQ_ADD, 0); q.run_status = stta_pkg::ST_RUNNING;
            pending_words.push_back(q);
        end
        wait_drained();

        // fill the table with a short ttl, overflow it, and tick
        write_ttl(8'd0);
        for (int i = 0; i < 22; i++) begin
            q = rand_word(stta_pkg::REQ_ADD, 0); q.run_status = 2'($urandom_range(1) * 2);
            pending_words.push_back(q);
        end
        q.req_type = stta_pkg::REQ_TICK; pending_words.push_back(q); pending_words.push_back(q);
        wait_drained();
        write_ttl(8'd255);

        // random phases with different idling and ttl settings
        send_idle_pct = 23; recv_idle_pct = 57;
        push_random(150, 40);
        wait_drained();
        write_ttl(8'd2);
        send_idle_pct = 57; recv_idle_pct = 23;
        push_random(80, 40);
        // hold the sender until every report has come back
        send_hold = 1'b1;
        while (s_valid || expected_reports.size() > 0) @(posedge aclk);
        send_hold = 1'b0;
        push_random(80, 0);
        wait_drained();
        write_ttl(8'd1);
        send_idle_pct = 0; recv_idle_pct = 0;
        push_random(114, 50);
        wait_drained();

        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

### service_table_with_ttl_aging_core.f
rtl/stta_pkg.sv
rtl/stta_ram.sv
rtl/stta_outq.sv
rtl/service_table_with_ttl_aging_core.sv
verif/tb.sv
